>>> rtl/core/isu_pkg.sv
// Shared types and codes for the indexed sequence store.
// No dependencies; every other file in rtl/core uses this package.
`timescale 1ns / 1ps

package isu_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned POS_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

  localparam logic signed [DATA_W-1:0] NO_VALUE = '1;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert_en;
    logic delete_en;
    logic [POS_W-1:0] position;
  } cell_cmd_t;

endpackage

>>> rtl/core/isu_req_if.sv
// Request channel of the indexed sequence store: valid, ready and the request fields.
// Depends on isu_pkg for field widths.
`timescale 1ns / 1ps

interface isu_req_if;
  logic valid;
  logic ready;
  logic [isu_pkg::MODE_W-1:0] mode;
  logic [isu_pkg::POS_W-1:0] position;
  logic signed [isu_pkg::DATA_W-1:0] item_value;

  modport source (output valid, output mode, output position, output item_value, input ready);
  modport sink (input valid, input mode, input position, input item_value, output ready);
endinterface

>>> rtl/core/isu_rsp_if.sv
// Response channel of the indexed sequence store: valid, ready and the result fields.
// Depends on isu_pkg for field widths.
`timescale 1ns / 1ps

interface isu_rsp_if;
  logic valid;
  logic ready;
  logic [isu_pkg::STAT_W-1:0] status;
  logic signed [isu_pkg::DATA_W-1:0] read_value;
  logic [isu_pkg::POS_W-1:0] entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink (input valid, input status, input read_value, input entry_count,
                output ready);
endinterface

>>> rtl/core/isu_cell.sv
// One storage cell of the sequence chain: holds one entry and shifts with its neighbors.
// Depends on isu_pkg for the command struct and data width.
`timescale 1ns / 1ps

module isu_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CMP_W = 5
) (
  input  logic clk,
  input  isu_pkg::cell_cmd_t cmd,
  input  logic signed [isu_pkg::DATA_W-1:0] item_value,
  input  logic signed [isu_pkg::DATA_W-1:0] left_value,
  input  logic signed [isu_pkg::DATA_W-1:0] right_value,
  output logic signed [isu_pkg::DATA_W-1:0] value
);

  logic [CMP_W-1:0] pos_ext;
  logic at_pos;
  logic after_pos;

  assign pos_ext = CMP_W'(cmd.position);
  assign at_pos = (pos_ext == CMP_W'(INDEX));
  assign after_pos = (CMP_W'(INDEX) > pos_ext);

  // Insert opens a gap at the target and pushes later entries up; delete
  // pulls the target and later entries down from the right neighbor.
  always_ff @(posedge clk) begin
    if (cmd.insert_en) begin
      if (at_pos) begin
        value <= item_value;
      end else if (after_pos) begin
        value <= left_value;
      end
    end else if (cmd.delete_en && (at_pos || after_pos)) begin
      value <= right_value;
    end
  end

endmodule

>>> rtl/core/indexed_sequence_store_unit.sv
// Top level of the indexed sequence store: request decode, count, cell chain, result register.
// Depends on isu_pkg, isu_req_if, isu_rsp_if and isu_cell.
`timescale 1ns / 1ps

// Channel  Direction  Fields                                   Transaction
// req      in         mode, position, item_value               valid & ready at clk edge
// rsp      out        status, read_value, entry_count          valid & ready at clk edge
//
// The decode against the count and a compare of the position in every
// cell settle in the cycle of acceptance, and the result is registered.
// One request is accepted in every cycle while no result is stalled.
// rst (synchronous, active high) empties the store; entries stay undefined
// until inserted and need no clearing pass. No request is taken while rst
// is high.
// A stalled result holds the output register and stops new requests; the
// block accepts again in the cycle in which the waiting result is taken.

module indexed_sequence_store_unit #(
  parameter int unsigned DEPTH = 16
) (
  input logic clk,
  input logic rst,
  isu_req_if.sink req,
  isu_rsp_if.source rsp
);

  localparam int unsigned POS_W = isu_pkg::POS_W;
  localparam int unsigned DATA_W = isu_pkg::DATA_W;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  // Compare width covers both the position field and the count.
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  // Only the first cells are reachable by a five-bit position.
  localparam int unsigned RD_N = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic fire;
  logic ins_ok;
  logic del_ok;
  logic [isu_pkg::STAT_W-1:0] status_next;
  logic signed [DATA_W-1:0] read_next;
  logic signed [DATA_W-1:0] rd_sel;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] cnt_next_ext;
  isu_pkg::cell_cmd_t cmd;
  logic signed [DATA_W-1:0] cell_value [DEPTH];

  // The output register parts the two sides: a new request is taken
  // whenever the waiting result leaves in the same cycle or none waits.
  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign fire = req.valid && req.ready;

  assign pos_ext = CMP_W'(req.position);
  assign cnt_ext = CMP_W'(count);

  // Read selection over the reachable cells.
  always_comb begin
    rd_sel = isu_pkg::NO_VALUE;
    for (int k = 0; k < RD_N; k++) begin
      if (req.position == POS_W'(k)) begin
        rd_sel = cell_value[k];
      end
    end
  end

  // Request decode. The empty test on delete comes before the position
  // test, and an unused mode is answered as ok with no change.
  always_comb begin
    status_next = isu_pkg::ST_OK;
    read_next = isu_pkg::NO_VALUE;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    count_next = count;
    unique case (req.mode)
      isu_pkg::MODE_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = isu_pkg::ST_BAD_POS;
        end else if (count == CNT_W'(DEPTH)) begin
          status_next = isu_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
          count_next = count + 1'b1;
        end
      end
      isu_pkg::MODE_DELETE: begin
        if (count == '0) begin
          status_next = isu_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = isu_pkg::ST_BAD_POS;
        end else begin
          del_ok = 1'b1;
          count_next = count - 1'b1;
        end
      end
      isu_pkg::MODE_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_next = isu_pkg::ST_BAD_POS;
        end else begin
          read_next = rd_sel;
        end
      end
      default: begin
        status_next = isu_pkg::ST_OK;
      end
    endcase
  end

  assign cnt_next_ext = CMP_W'(count_next);

  assign cmd.insert_en = fire && ins_ok;
  assign cmd.delete_en = fire && del_ok;
  assign cmd.position = req.position;

  // The chain: each cell sees its left neighbor for an insert and its right
  // neighbor for a delete. The head has no left neighbor and the tail keeps
  // its own value when the chain closes up.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_value = req.item_value;
    end else begin : g_left
      assign left_value = cell_value[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_value = cell_value[i];
    end else begin : g_right
      assign right_value = cell_value[i+1];
    end

    isu_cell #(
      .INDEX(i),
      .CMP_W(CMP_W)
    ) u_cell (
      .clk(clk),
      .cmd(cmd),
      .item_value(req.item_value),
      .left_value(left_value),
      .right_value(right_value),
      .value(cell_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Result payload; the reported count is masked to the field width.
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.status <= status_next;
      rsp.read_value <= read_next;
      rsp.entry_count <= cnt_next_ext[POS_W-1:0];
    end
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  // A successful insert grows the store by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && ins_ok) |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the count by one");

  // A successful delete shrinks the store by exactly one entry.
  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    (fire && del_ok) |=> (count == $past(count) - 1'b1))
    else $error("delete did not shrink the count by one");

  // A full report is only given while the store really is full.
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == isu_pkg::ST_FULL) |-> (count == CNT_W'(DEPTH)))
    else $error("full status reported on a store that is not full");

  // A waiting result blocks new requests.
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request accepted while a result is stalled");

endmodule
